/* rtl/core/bgtr_pkg.sv */
// Shared types, codes and constants of the bitmap glyph text renderer.
`default_nettype none

package bgtr_pkg;

    // Fixed field widths of the stream payloads.
    localparam int OFFSET_W     = 24;
    localparam int ROW_W        = 32;
    localparam int SPAN_W       = 16;
    localparam int COLOR_W      = 8;
    localparam int LOAD_W       = 32;
    localparam int CODE_W       = 8;
    localparam int ROW_IDX_W    = 5;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 80;

    // A string draws at most this many glyph rows per character.
    localparam int ROWS_CAP     = 32;
    localparam int YCNT_W       = 5;
    localparam int ROWS_W       = 6;

    // Bit positions inside style_flags.
    localparam int STYLE_MONO   = 0;
    localparam int STYLE_ULINE  = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_WIDTH = 2'd0,
        CMD_LOAD_ROW   = 2'd1,
        CMD_DRAW       = 2'd2
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLYPH_COUNT     = 3'd0,
        REG_LINE_HEIGHT     = 3'd1,
        REG_LETTER_SPACING  = 3'd2,
        REG_MONO_CELL_WIDTH = 3'd3,
        REG_CLIP_WIDTH      = 3'd4,
        REG_ROW_PITCH       = 3'd5,
        REG_DRAW_COLOR      = 3'd6,
        REG_STYLE_FLAGS     = 3'd7
    } t_cfg_index;

    typedef enum logic {
        KIND_ROW  = 1'b0,
        KIND_SPAN = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DECIDE,
        ST_ROWS,
        ST_TAIL
    } t_state;

    typedef struct packed {
        logic [8:0]  glyph_count;
        logic [5:0]  line_height;
        logic [4:0]  letter_spacing;
        logic [5:0]  mono_cell_width;
        logic [15:0] clip_width;
        logic [12:0] row_pitch;
        logic [7:0]  draw_color;
        logic [1:0]  style_flags;
    } t_cfg;

    typedef struct packed {
        logic wr_width;
        logic wr_row;
        logic capture;
        logic calc;
        logic decide;
        logic emit_row;
        logic emit_span;
        logic end_string;
    } t_ctrl_cmd;

    typedef struct packed {
        logic drawable;
        logic cut;
        logic row_last;
        logic out_free;
        logic span_need;
        logic last_char;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/core/bgtr_ctrl.sv */
// Sequencing state machine of the bitmap glyph text renderer.
`default_nettype none

module bgtr_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [bgtr_pkg::CMD_W-1:0]   i_command,
    output logic                              o_in_ready,
    input  wire bgtr_pkg::t_dp_status         i_status,
    output bgtr_pkg::t_ctrl_cmd               o_cmd
);

    bgtr_pkg::t_state r_state;
    bgtr_pkg::t_state n_state;
    logic             accept;

    assign o_in_ready = (r_state == bgtr_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgtr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            bgtr_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (bgtr_pkg::t_command'(i_command))
                        bgtr_pkg::CMD_LOAD_WIDTH: o_cmd.wr_width = 1'b1;
                        bgtr_pkg::CMD_LOAD_ROW:   o_cmd.wr_row = 1'b1;
                        bgtr_pkg::CMD_DRAW: begin
                            o_cmd.capture = 1'b1;
                            n_state       = bgtr_pkg::ST_CALC;
                        end
                        default: ;
                    endcase
                end
            end
            bgtr_pkg::ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = bgtr_pkg::ST_DECIDE;
            end
            bgtr_pkg::ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_status.drawable && !i_status.cut) begin
                    n_state = bgtr_pkg::ST_ROWS;
                end else begin
                    n_state = bgtr_pkg::ST_TAIL;
                end
            end
            bgtr_pkg::ST_ROWS: begin
                if (i_status.out_free) begin
                    o_cmd.emit_row = 1'b1;
                    if (i_status.row_last) begin
                        n_state = bgtr_pkg::ST_TAIL;
                    end
                end
            end
            bgtr_pkg::ST_TAIL: begin
                if (i_status.span_need) begin
                    if (i_status.out_free) begin
                        o_cmd.emit_span  = 1'b1;
                        o_cmd.end_string = 1'b1;
                        n_state          = bgtr_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.end_string = i_status.last_char;
                    n_state          = bgtr_pkg::ST_IDLE;
                end
            end
            default: n_state = bgtr_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/bgtr_datapath.sv */
// Glyph tables, pen arithmetic and result register of the text renderer.
`default_nettype none

module bgtr_datapath #(
    parameter int GLYPH_SLOTS     = 256,
    parameter int MAX_ROWS        = 32,
    parameter int MAX_GLYPH_WIDTH = 32,
    parameter int PEN_BITS        = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire bgtr_pkg::t_cfg                      i_cfg,
    input  wire bgtr_pkg::t_ctrl_cmd                 i_cmd,
    output bgtr_pkg::t_dp_status                     o_status,
    input  wire logic [bgtr_pkg::CODE_W-1:0]         i_code,
    input  wire logic [bgtr_pkg::ROW_IDX_W-1:0]      i_row,
    input  wire logic [bgtr_pkg::LOAD_W-1:0]         i_load_value,
    input  wire logic                                i_last_char,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic                                     o_out_kind,
    output logic [bgtr_pkg::OFFSET_W-1:0]            o_pixel_offset,
    output logic [bgtr_pkg::ROW_W-1:0]               o_row_bits,
    output logic [bgtr_pkg::SPAN_W-1:0]              o_span_length,
    output logic [bgtr_pkg::COLOR_W-1:0]             o_pixel_color,
    output logic                                     o_out_last
);

    localparam int CW    = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
    localparam int WW    = $clog2(MAX_GLYPH_WIDTH + 1);
    localparam int DEPTH = GLYPH_SLOTS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = ((PEN_BITS > 16) ? PEN_BITS : 16) + 2;
    localparam int RMAX  = (MAX_ROWS < bgtr_pkg::ROWS_CAP) ? MAX_ROWS : bgtr_pkg::ROWS_CAP;
    localparam logic [XW-1:0] PEN_TOP = XW'((1 << PEN_BITS) - 1);

    // Glyph storage, neither cleared at reset.
    logic [WW-1:0]                 r_width_mem [GLYPH_SLOTS];
    logic [bgtr_pkg::LOAD_W-1:0]   r_row_mem   [DEPTH];

    // Per-character working registers.
    logic [bgtr_pkg::CODE_W-1:0]   r_code;
    logic                          r_last;
    logic [WW-1:0]                 r_w;
    logic [bgtr_pkg::ROW_W-1:0]    r_rowdata;
    logic signed [XW-1:0]          r_x;
    logic signed [XW-1:0]          r_end;
    logic [bgtr_pkg::OFFSET_W-1:0] r_span_off;
    logic [bgtr_pkg::OFFSET_W-1:0] r_row_off;
    logic                          r_drawable;
    logic [bgtr_pkg::YCNT_W-1:0]   r_rows_m1;
    logic [bgtr_pkg::YCNT_W-1:0]   r_y;
    logic [AW-1:0]                 r_base;
    logic [bgtr_pkg::ROW_W-1:0]    r_mask;

    // String state.
    logic [PEN_BITS-1:0]           r_pen;
    logic                          r_stopped;

    // Result register.
    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [bgtr_pkg::OFFSET_W-1:0] r_out_off;
    logic [bgtr_pkg::ROW_W-1:0]    r_out_bits;
    logic [bgtr_pkg::SPAN_W-1:0]   r_out_len;
    logic [bgtr_pkg::COLOR_W-1:0]  r_out_color;
    logic                          r_out_last;

    logic                          code_ok;
    logic                          row_ok;
    logic [WW-1:0]                 width_wr;
    logic [AW-1:0]                 wr_addr;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          mono;
    logic signed [XW-1:0]          s_pen;
    logic signed [XW-1:0]          s_w;
    logic signed [XW-1:0]          s_sp;
    logic signed [XW-1:0]          s_cell;
    logic signed [XW-1:0]          s_d;
    logic signed [XW-1:0]          s_half;
    logic signed [XW-1:0]          s_x;
    logic signed [XW-1:0]          s_end;
    logic [bgtr_pkg::ROWS_W-1:0]   rows_calc;
    logic [17:0]                   span_prod;
    logic                          drawable_calc;
    logic [bgtr_pkg::ROW_W-1:0]    mask_calc;
    logic                          cut;
    logic                          row_last;
    logic                          span_need;
    logic                          out_free;
    logic [31:0]                   x_ext;

    function automatic logic [PEN_BITS-1:0] pen_clamp(input logic signed [XW-1:0] v);
        logic [PEN_BITS-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > signed'(PEN_TOP)) begin
            res = PEN_TOP[PEN_BITS-1:0];
        end else begin
            res = v[PEN_BITS-1:0];
        end
        return res;
    endfunction

    // Load handling.
    assign code_ok  = ({1'b0, i_code} < 9'(GLYPH_SLOTS));
    assign row_ok   = ({2'b0, i_row} < 7'(MAX_ROWS));
    assign width_wr = (i_load_value > 32'(MAX_GLYPH_WIDTH)) ? WW'(MAX_GLYPH_WIDTH)
                                                            : i_load_value[WW-1:0];
    assign wr_addr  = AW'({6'b0, i_code} * 14'(MAX_ROWS) + {9'b0, i_row});

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_width && code_ok) begin
            r_width_mem[i_code[CW-1:0]] <= width_wr;
        end
        if (i_cmd.capture) begin
            r_w <= r_width_mem[i_code[CW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_row && code_ok && row_ok) begin
            r_row_mem[wr_addr] <= i_load_value;
        end
        if (rd_en) begin
            r_rowdata <= r_row_mem[rd_addr];
        end
    end

    // Cell geometry; the centring offset is halved with truncation toward zero.
    always_comb begin
        mono   = i_cfg.style_flags[bgtr_pkg::STYLE_MONO];
        s_pen  = signed'(XW'(r_pen));
        s_w    = signed'(XW'(r_w));
        s_sp   = signed'(XW'(i_cfg.letter_spacing));
        s_cell = signed'(XW'(i_cfg.mono_cell_width));
        s_d    = s_cell - s_sp - s_w;
        s_half = s_d[XW-1] ? -((-s_d) >>> 1) : (s_d >>> 1);
        s_x    = mono ? (s_pen + s_half) : s_pen;
        s_end  = mono ? (s_pen + s_cell) : (s_pen + s_w + s_sp);

        if (i_cfg.line_height == '0) begin
            rows_calc = bgtr_pkg::ROWS_W'(1);
        end else if (i_cfg.line_height > bgtr_pkg::ROWS_W'(RMAX)) begin
            rows_calc = bgtr_pkg::ROWS_W'(RMAX);
        end else begin
            rows_calc = i_cfg.line_height;
        end
        span_prod = 18'(i_cfg.row_pitch) * 18'(rows_calc - 6'd1);

        drawable_calc = !r_stopped && ({1'b0, r_code} < i_cfg.glyph_count)
                        && ({1'b0, r_code} < 9'(GLYPH_SLOTS));

        if (32'(r_w) >= 32'(bgtr_pkg::ROW_W)) begin
            mask_calc = '1;
        end else begin
            mask_calc = ~({bgtr_pkg::ROW_W{1'b1}} >> r_w);
        end
    end

    assign cut       = (r_end > signed'(XW'(i_cfg.clip_width)));
    assign row_last  = (r_y == r_rows_m1);
    assign span_need = r_last && i_cfg.style_flags[bgtr_pkg::STYLE_ULINE] && (r_pen != '0);
    assign out_free  = !r_out_valid || i_out_ready;
    assign x_ext     = 32'(r_x);

    // Row store read: row zero after the clip check, the next row with each emit.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_base;
        if (i_cmd.decide && r_drawable && !cut) begin
            rd_en = 1'b1;
        end else if (i_cmd.emit_row && !row_last) begin
            rd_en   = 1'b1;
            rd_addr = r_base + AW'({1'b0, r_y} + 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code <= i_code;
            r_last <= i_last_char;
        end
        if (i_cmd.calc) begin
            r_x        <= s_x;
            r_end      <= s_end;
            r_span_off <= bgtr_pkg::OFFSET_W'(span_prod);
            r_drawable <= drawable_calc;
            r_rows_m1  <= bgtr_pkg::YCNT_W'(rows_calc - 6'd1);
            r_base     <= AW'({6'b0, r_code} * 14'(MAX_ROWS));
            r_mask     <= mask_calc;
        end
        if (i_cmd.decide) begin
            r_y       <= '0;
            r_row_off <= '0;
        end else if (i_cmd.emit_row && !row_last) begin
            r_y       <= r_y + 5'd1;
            r_row_off <= r_row_off + bgtr_pkg::OFFSET_W'(i_cfg.row_pitch);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen     <= '0;
            r_stopped <= 1'b0;
        end else if (i_cmd.end_string) begin
            r_pen     <= '0;
            r_stopped <= 1'b0;
        end else if (i_cmd.decide && r_drawable) begin
            if (cut) begin
                r_stopped <= 1'b1;
                r_pen     <= pen_clamp(r_x);
            end else begin
                r_pen <= pen_clamp(r_end);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_row || i_cmd.emit_span) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_row) begin
            r_out_kind  <= bgtr_pkg::KIND_ROW;
            r_out_off   <= r_row_off + x_ext[bgtr_pkg::OFFSET_W-1:0];
            r_out_bits  <= r_rowdata & r_mask;
            r_out_len   <= bgtr_pkg::SPAN_W'(r_w);
            r_out_color <= i_cfg.draw_color;
            r_out_last  <= row_last && !span_need;
        end else if (i_cmd.emit_span) begin
            r_out_kind  <= bgtr_pkg::KIND_SPAN;
            r_out_off   <= r_span_off;
            r_out_bits  <= '0;
            r_out_len   <= bgtr_pkg::SPAN_W'(r_pen);
            r_out_color <= i_cfg.draw_color;
            r_out_last  <= 1'b1;
        end
    end

    assign o_status.drawable  = r_drawable;
    assign o_status.cut       = cut;
    assign o_status.row_last  = row_last;
    assign o_status.out_free  = out_free;
    assign o_status.span_need = span_need;
    assign o_status.last_char = r_last;

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out_kind;
    assign o_pixel_offset = r_out_off;
    assign o_row_bits     = r_out_bits;
    assign o_span_length  = r_out_len;
    assign o_pixel_color  = r_out_color;
    assign o_out_last     = r_out_last;

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_row || i_cmd.emit_span) |-> out_free)
        else $error("result loaded while the output register was still full");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.capture, i_cmd.calc, i_cmd.decide, i_cmd.emit_row, i_cmd.emit_span}))
        else $error("more than one datapath step commanded at once");

    a_string_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.end_string |=> (r_pen == '0 && !r_stopped))
        else $error("pen or stop flag survived the end of a string");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_row |-> (r_y <= r_rows_m1))
        else $error("glyph row counter ran past the line height");
`endif

endmodule

`default_nettype wire

/* rtl/core/bitmap_glyph_text_renderer.sv */
// Top level of the bitmap glyph text renderer: ports, register bank and wiring.
`default_nettype none

// One-bit bitmap font text blitter. Glyph widths (command 0) and glyph rows
// (command 1) are loaded through the input stream; each load is a single
// transfer that produces no result and leaves the block ready for the next
// one. A draw (command 2) places one character at the pen and sends one
// row-mask result per glyph row, MSB leftmost, followed on the last
// character of a string (s_axis_tlast) by an underline span when underline
// mode is on and the pen has moved. Once a cell would end beyond clip_width
// the rest of the string is skipped, but tlast still ends it. A draw
// occupies the block through the width lookup, the cell geometry and the
// clip check, then one glyph row per cycle, paced by the single read port of
// the row store, and a closing step that also carries the underline span
// when one is due. A skipped character goes from the clip check straight to
// the closing step. Output backpressure stretches the row phase and, when a
// span is due, the closing step; the result register lets the next input
// transfer be taken while the final result is still waiting. The glyph
// tables are not cleared at reset, so every glyph must be loaded before it
// is drawn; there is no clearing pass and the block is ready right after
// reset. The configuration channel is always ready and should only be
// written while no draw is being processed.

module bitmap_glyph_text_renderer #(
    parameter int GLYPH_SLOTS     = 256,
    parameter int MAX_ROWS        = 32,
    parameter int MAX_GLYPH_WIDTH = 32,
    parameter int PEN_BITS        = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration write channel.
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [bgtr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bgtr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Input stream.
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: char_code[7:0], row_index[12:8], load_value[44:13], zero [47:45]
    input  wire logic [bgtr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: command[1:0]
    input  wire logic [bgtr_pkg::CMD_W-1:0]           s_axis_tuser,
    input  wire logic                                 s_axis_tlast,
    // Output stream.
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata: pixel_offset[23:0], row_bits[55:24], span_length[71:56],
    //        pixel_color[79:72]
    output logic [bgtr_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // tuser: kind[0]
    output logic                                      m_axis_tuser,
    output logic                                      m_axis_tlast
);

    bgtr_pkg::t_cfg        r_cfg;
    bgtr_pkg::t_ctrl_cmd   cmd;
    bgtr_pkg::t_dp_status  status;

    logic [bgtr_pkg::OFFSET_W-1:0] pixel_offset;
    logic [bgtr_pkg::ROW_W-1:0]    row_bits;
    logic [bgtr_pkg::SPAN_W-1:0]   span_length;
    logic [bgtr_pkg::COLOR_W-1:0]  pixel_color;

    // Register bank: every write transfer is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_count     <= 9'd0;
            r_cfg.line_height     <= 6'd1;
            r_cfg.letter_spacing  <= 5'd0;
            r_cfg.mono_cell_width <= 6'd0;
            r_cfg.clip_width      <= 16'hFFFF;
            r_cfg.row_pitch       <= 13'd640;
            r_cfg.draw_color      <= 8'd0;
            r_cfg.style_flags     <= 2'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (bgtr_pkg::t_cfg_index'(i_cfg_index))
                bgtr_pkg::REG_GLYPH_COUNT:     r_cfg.glyph_count     <= i_cfg_data[8:0];
                bgtr_pkg::REG_LINE_HEIGHT:     r_cfg.line_height     <= i_cfg_data[5:0];
                bgtr_pkg::REG_LETTER_SPACING:  r_cfg.letter_spacing  <= i_cfg_data[4:0];
                bgtr_pkg::REG_MONO_CELL_WIDTH: r_cfg.mono_cell_width <= i_cfg_data[5:0];
                bgtr_pkg::REG_CLIP_WIDTH:      r_cfg.clip_width      <= i_cfg_data;
                bgtr_pkg::REG_ROW_PITCH:       r_cfg.row_pitch       <= i_cfg_data[12:0];
                bgtr_pkg::REG_DRAW_COLOR:      r_cfg.draw_color      <= i_cfg_data[7:0];
                bgtr_pkg::REG_STYLE_FLAGS:     r_cfg.style_flags     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    bgtr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_command  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bgtr_datapath #(
        .GLYPH_SLOTS     (GLYPH_SLOTS),
        .MAX_ROWS        (MAX_ROWS),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
        .PEN_BITS        (PEN_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_code         (s_axis_tdata[7:0]),
        .i_row          (s_axis_tdata[12:8]),
        .i_load_value   (s_axis_tdata[44:13]),
        .i_last_char    (s_axis_tlast),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_kind     (m_axis_tuser),
        .o_pixel_offset (pixel_offset),
        .o_row_bits     (row_bits),
        .o_span_length  (span_length),
        .o_pixel_color  (pixel_color),
        .o_out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {pixel_color, span_length, row_bits, pixel_offset};

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// Stream testbench of the bitmap glyph text renderer with its own glyph, pen and clip predictor.
module tb;

    // Command code 3 has no meaning; the block must ignore it.
    localparam logic [bgtr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    // A draw keeps the block busy through its lookup, rows and closing step, even when the output keeps up.
    localparam int DRAIN_CYCLES = 48;
    // Length of the long output stall that backs the block up into its input.
    localparam int HOLD_CYCLES  = 400;
    localparam int PEN_TOP      = (1 << 16) - 1;

    typedef struct packed {
        logic [bgtr_pkg::CMD_W-1:0]     cmd;
        logic [bgtr_pkg::CODE_W-1:0]    code;
        logic [bgtr_pkg::ROW_IDX_W-1:0] row;
        logic [bgtr_pkg::LOAD_W-1:0]    value;
        logic                           last_char;
    } t_glyph_cmd;

    typedef struct packed {
        logic                          kind;
        logic [bgtr_pkg::OFFSET_W-1:0] offset;
        logic [bgtr_pkg::ROW_W-1:0]    bits;
        logic [bgtr_pkg::SPAN_W-1:0]   span;
        logic [bgtr_pkg::COLOR_W-1:0]  color;
        logic                          last;
    } t_blit_word;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [bgtr_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [bgtr_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [bgtr_pkg::IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [bgtr_pkg::CMD_W-1:0]      s_axis_tuser  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [bgtr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;

    bitmap_glyph_text_renderer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: register copy, glyph tables, pen and stop flag.
    // ------------------------------------------------------------------
    bgtr_pkg::t_cfg cfg_m;
    logic [5:0]     width_mem [256];
    logic [31:0]    row_mem [8192];
    int             pen;
    logic           stopped;
    t_blit_word     blit_q [$];      // results still owed by the block, oldest first
    int             errors = 0;

    function automatic int pen_limit(input int v);
        if (v < 0) return 0;
        if (v > PEN_TOP) return PEN_TOP;
        return v;
    endfunction

    // Applies one accepted input transfer to the predictor and queues the
    // results that it must cause.
    task automatic render_item(input t_glyph_cmd c);
        int          rows;
        int          w;
        int          sp;
        int          x;
        int          cell_end;
        int          y;
        logic [31:0] mask;
        logic [31:0] off;
        t_blit_word  r;
        t_blit_word  pend [$];
        rows = (cfg_m.line_height == 0) ? 1 : int'(cfg_m.line_height);
        if (rows > bgtr_pkg::ROWS_CAP) rows = bgtr_pkg::ROWS_CAP;
        case (c.cmd)
            bgtr_pkg::CMD_LOAD_WIDTH: begin
                width_mem[c.code] = (c.value > 32) ? 6'd32 : c.value[5:0];
            end
            bgtr_pkg::CMD_LOAD_ROW: begin
                row_mem[{c.code, c.row}] = c.value;
            end
            bgtr_pkg::CMD_DRAW: begin
                if (!stopped && c.code < cfg_m.glyph_count) begin
                    w  = int'(width_mem[c.code]);
                    sp = int'(cfg_m.letter_spacing);
                    x  = pen;
                    if (cfg_m.style_flags[bgtr_pkg::STYLE_MONO]) begin
                        // The glyph is centered in the cell; a narrow cell gives a
                        // negative x, which wraps in the pixel offset.
                        cell_end = x + int'(cfg_m.mono_cell_width);
                        x = x + (int'(cfg_m.mono_cell_width) - sp - w) / 2;
                    end else begin
                        cell_end = x + w + sp;
                    end
                    if (cell_end > int'(cfg_m.clip_width)) begin
                        // The clip stops the string; the centered pen is kept.
                        stopped = 1'b1;
                        pen = pen_limit(x);
                    end else begin
                        mask = (w >= 32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> w);
                        for (y = 0; y < rows; y++) begin
                            off      = y * cfg_m.row_pitch + x;
                            r.kind   = bgtr_pkg::KIND_ROW;
                            r.offset = off[bgtr_pkg::OFFSET_W-1:0];
                            r.bits   = row_mem[{c.code, y[4:0]}] & mask;
                            r.span   = 16'(w);
                            r.color  = cfg_m.draw_color;
                            r.last   = 1'b0;
                            pend.push_back(r);
                        end
                        pen = pen_limit(cell_end);
                    end
                end
                if (c.last_char) begin
                    if (cfg_m.style_flags[bgtr_pkg::STYLE_ULINE] && pen > 0) begin
                        off      = cfg_m.row_pitch * (rows - 1);
                        r.kind   = bgtr_pkg::KIND_SPAN;
                        r.offset = off[bgtr_pkg::OFFSET_W-1:0];
                        r.bits   = '0;
                        r.span   = 16'(pen);
                        r.color  = cfg_m.draw_color;
                        r.last   = 1'b0;
                        pend.push_back(r);
                    end
                    pen     = 0;
                    stopped = 1'b0;
                end
            end
            default: ;
        endcase
        if (pend.size() > 0) begin
            r = pend.pop_back();
            r.last = 1'b1;
            pend.push_back(r);
        end
        foreach (pend[i]) blit_q.push_back(pend[i]);
    endtask

    // ------------------------------------------------------------------
    // Input driver: items leave cmd_q one per transfer, with random gaps.
    // ------------------------------------------------------------------
    t_glyph_cmd cmd_q [$];
    t_glyph_cmd tx_item   = '0;
    logic       tx_busy   = 1'b0;
    logic       tx_taken  = 1'b0;
    logic       tx_steady = 1'b0;
    int         tx_gap    = 0;
    int         pushed    = 0;
    int         accepted  = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            render_item(tx_item);
            accepted++;
            tx_taken = 1'b1;
        end
    end

    // A transfer at the last rising edge frees the slot; the next item goes
    // out after its own gap. Runs of zero gaps come and go at random.
    always @(negedge i_clk) begin
        if (tx_taken) begin
            tx_taken = 1'b0;
            tx_busy  = 1'b0;
            if ($urandom_range(0, 19) == 0) tx_steady = ~tx_steady;
            tx_gap = tx_steady ? 0 : $urandom_range(0, 16);
        end
        if (!tx_busy) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (cmd_q.size() > 0) begin
                tx_item = cmd_q.pop_front();
                tx_busy = 1'b1;
            end
        end
        s_axis_tvalid <= tx_busy;
        s_axis_tdata  <= {3'b000, tx_item.value, tx_item.row, tx_item.code};
        s_axis_tuser  <= tx_item.cmd;
        s_axis_tlast  <= tx_item.last_char;
    end

    // ------------------------------------------------------------------
    // Output side: random ready pattern and the result check.
    // ------------------------------------------------------------------
    logic rx_taken  = 1'b0;
    logic rx_steady = 1'b0;
    logic rx_hold   = 1'b0;
    logic hold_go   = 1'b0;
    int   rx_wait   = 0;

    always @(negedge i_clk) begin
        if (rx_taken) begin
            rx_taken = 1'b0;
            if ($urandom_range(0, 29) == 0) rx_steady = ~rx_steady;
            rx_wait = rx_steady ? 0 : $urandom_range(0, 16);
        end
        if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // One long stall, counted here, while the driver keeps offering items,
    // so that the block backs up and drops s_axis_tready.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_blit_word got;
        t_blit_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_taken = 1'b1;
            got.kind   = m_axis_tuser;
            got.offset = m_axis_tdata[23:0];
            got.bits   = m_axis_tdata[55:24];
            got.span   = m_axis_tdata[71:56];
            got.color  = m_axis_tdata[79:72];
            got.last   = m_axis_tlast;
            if (blit_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = blit_q.pop_front();
                report_field("kind", want.kind, got.kind);
                report_field("pixel_offset", want.offset, got.offset);
                report_field("row_bits", want.bits, got.bits);
                report_field("span_length", want.span, got.span);
                report_field("pixel_color", want.color, got.color);
                report_field("last", want.last, got.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Register writes. The valid stays high across the writes of one
    // setting and drops after the last of them.
    // ------------------------------------------------------------------
    task automatic write_reg(input bgtr_pkg::t_cfg_index idx,
                             input logic [bgtr_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        case (idx)
            bgtr_pkg::REG_GLYPH_COUNT:     cfg_m.glyph_count     = val[8:0];
            bgtr_pkg::REG_LINE_HEIGHT:     cfg_m.line_height     = val[5:0];
            bgtr_pkg::REG_LETTER_SPACING:  cfg_m.letter_spacing  = val[4:0];
            bgtr_pkg::REG_MONO_CELL_WIDTH: cfg_m.mono_cell_width = val[5:0];
            bgtr_pkg::REG_CLIP_WIDTH:      cfg_m.clip_width      = val[15:0];
            bgtr_pkg::REG_ROW_PITCH:       cfg_m.row_pitch       = val[12:0];
            bgtr_pkg::REG_DRAW_COLOR:      cfg_m.draw_color      = val[7:0];
            bgtr_pkg::REG_STYLE_FLAGS:     cfg_m.style_flags     = val[1:0];
            default: ;
        endcase
    endtask

    // Generator view of what has been loaded, so that no draw ever reads a
    // glyph entry that was never written.
    logic        gen_width_ok [256];
    logic [31:0] gen_rows_ok [256];
    int          gen_rows  = 1;
    int          gen_count = 0;
    int          font_pool [$];

    task automatic set_cfg(input int gc, input int lh, input int sp, input int cell_w,
                           input int clip, input int pitch, input int color,
                           input int style);
        write_reg(bgtr_pkg::REG_GLYPH_COUNT, 16'(gc));
        write_reg(bgtr_pkg::REG_LINE_HEIGHT, 16'(lh));
        write_reg(bgtr_pkg::REG_LETTER_SPACING, 16'(sp));
        write_reg(bgtr_pkg::REG_MONO_CELL_WIDTH, 16'(cell_w));
        write_reg(bgtr_pkg::REG_CLIP_WIDTH, 16'(clip));
        write_reg(bgtr_pkg::REG_ROW_PITCH, 16'(pitch));
        write_reg(bgtr_pkg::REG_DRAW_COLOR, 16'(color));
        write_reg(bgtr_pkg::REG_STYLE_FLAGS, 16'(style));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_count = gc;
        gen_rows  = (lh == 0) ? 1 : ((lh > bgtr_pkg::ROWS_CAP) ? bgtr_pkg::ROWS_CAP : lh);
    endtask

    // Waits until every item is taken and every result has arrived, then
    // lets a skipped draw or a load still in flight run out.
    task automatic wait_quiet();
        @(negedge i_clk);
        while (accepted != pushed || blit_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    int useful = 0;   // items the block acts on; ignored commands are not counted

    task automatic push_cmd(input logic [bgtr_pkg::CMD_W-1:0] cmd, input int code,
                            input int row, input logic [31:0] val, input int lastc);
        t_glyph_cmd c;
        c.cmd       = cmd;
        c.code      = 8'(code);
        c.row       = 5'(row);
        c.value     = val;
        c.last_char = (lastc != 0);
        if (cmd == bgtr_pkg::CMD_LOAD_WIDTH) gen_width_ok[code] = 1'b1;
        if (cmd == bgtr_pkg::CMD_LOAD_ROW) gen_rows_ok[code][row] = 1'b1;
        if (cmd != CMD_UNUSED) useful++;
        cmd_q.push_back(c);
        pushed++;
    endtask

    function automatic logic glyph_usable(input int code);
        logic [31:0] need;
        need = (gen_rows >= 32) ? 32'hFFFF_FFFF : ((32'd1 << gen_rows) - 32'd1);
        if (code >= gen_count) return 1'b1;
        return gen_width_ok[code] && ((gen_rows_ok[code] & need) == need);
    endfunction

    // Loads a width (sometimes far above the cap) and every row in use.
    task automatic load_glyph(input int code);
        logic [31:0] wv;
        int          r;
        wv = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 34);
        push_cmd(bgtr_pkg::CMD_LOAD_WIDTH, code, $urandom_range(0, 31), wv,
                 $urandom_range(0, 1));
        for (r = 0; r < gen_rows; r++) begin
            push_cmd(bgtr_pkg::CMD_LOAD_ROW, code, r, $urandom, $urandom_range(0, 1));
        end
        font_pool.push_back(code);
    endtask

    // A well-formed string: draws of loaded glyphs, tlast on the final one.
    task automatic draw_string(input int len);
        int k;
        int code;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0) code = $urandom_range(0, 255);
            else code = font_pool[$urandom_range(0, font_pool.size() - 1)];
            if (!glyph_usable(code)) load_glyph(code);
            push_cmd(bgtr_pkg::CMD_DRAW, code, $urandom_range(0, 31), $urandom,
                     (k == len - 1) ? 1 : 0);
        end
    endtask

    task automatic random_phase(input int budget);
        int stop_at;
        int code;
        stop_at = useful + budget;
        while (useful < stop_at) begin
            case ($urandom_range(0, 9))
                0: load_glyph($urandom_range(0, 255));
                1: push_cmd(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 31),
                            $urandom, $urandom_range(0, 1));
                2: push_cmd(bgtr_pkg::CMD_LOAD_ROW, $urandom_range(0, 255),
                            $urandom_range(0, 31), $urandom, $urandom_range(0, 1));
                3: begin
                    // Lone draw with a random tlast; strings may run on.
                    code = $urandom_range(0, 255);
                    if (glyph_usable(code)) begin
                        push_cmd(bgtr_pkg::CMD_DRAW, code, $urandom_range(0, 31), $urandom,
                                 $urandom_range(0, 1));
                    end
                end
                default: draw_string($urandom_range(1, 6));
            endcase
        end
        // Close any open string before the registers change.
        draw_string(1);
    endtask

    // Limit: far above the slowest correct run, in which every result is held
    // for the longest random wait and every row of every glyph is in use.
    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        cfg_m.glyph_count     = 9'd0;
        cfg_m.line_height     = 6'd1;
        cfg_m.letter_spacing  = 5'd0;
        cfg_m.mono_cell_width = 6'd0;
        cfg_m.clip_width      = 16'hFFFF;
        cfg_m.row_pitch       = 13'd640;
        cfg_m.draw_color      = 8'd0;
        cfg_m.style_flags     = 2'd0;
        pen     = 0;
        stopped = 1'b0;
        foreach (gen_width_ok[i]) gen_width_ok[i] = 1'b0;
        foreach (gen_rows_ok[i]) gen_rows_ok[i] = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Proportional with underline: zero, full and capped widths, all-ones
        // and edge pixel rows, the top code and the ignored command.
        set_cfg(256, 2, 3, 0, 16'hFFFF, 4096, 8'hFF, 2);
        push_cmd(bgtr_pkg::CMD_LOAD_WIDTH, 0, 0, 32'd0, 0);
        push_cmd(bgtr_pkg::CMD_LOAD_WIDTH, 255, 31, 32'd32, 1);
        push_cmd(bgtr_pkg::CMD_LOAD_WIDTH, 1, 0, 32'hFFFF_FFFF, 0);
        push_cmd(bgtr_pkg::CMD_LOAD_ROW, 0, 0, 32'hFFFF_FFFF, 0);
        push_cmd(bgtr_pkg::CMD_LOAD_ROW, 0, 1, 32'h8000_0001, 0);
        push_cmd(bgtr_pkg::CMD_LOAD_ROW, 255, 0, 32'hFFFF_FFFF, 1);
        push_cmd(bgtr_pkg::CMD_LOAD_ROW, 255, 1, 32'h8000_0000, 0);
        push_cmd(bgtr_pkg::CMD_LOAD_ROW, 1, 0, 32'h0000_0000, 0);
        push_cmd(bgtr_pkg::CMD_LOAD_ROW, 1, 1, 32'hAAAA_AAAA, 0);
        push_cmd(bgtr_pkg::CMD_LOAD_ROW, 255, 31, 32'h5555_5555, 0);
        push_cmd(CMD_UNUSED, 255, 31, 32'hFFFF_FFFF, 1);
        push_cmd(bgtr_pkg::CMD_DRAW, 255, 0, 32'd0, 0);
        push_cmd(bgtr_pkg::CMD_DRAW, 0, 0, 32'd0, 0);
        push_cmd(bgtr_pkg::CMD_DRAW, 1, 0, 32'd0, 1);
        push_cmd(bgtr_pkg::CMD_DRAW, 255, 0, 32'd0, 1);
        font_pool.push_back(0);
        font_pool.push_back(1);
        font_pool.push_back(255);
        wait_quiet();

        // Monospaced with underline: a code above the glyph count is skipped, a
        // glyph wider than the cell lands at a negative x, the next cell
        // passes the clip, and the character after the stop draws nothing
        // while the underline keeps the centered pen.
        set_cfg(2, 2, 0, 10, 20, 4096, 8'h80, 3);
        push_cmd(bgtr_pkg::CMD_DRAW, 0, 0, 32'd0, 0);
        push_cmd(bgtr_pkg::CMD_DRAW, 255, 0, 32'd0, 0);
        push_cmd(bgtr_pkg::CMD_DRAW, 1, 0, 32'd0, 0);
        push_cmd(bgtr_pkg::CMD_DRAW, 0, 0, 32'd0, 0);
        push_cmd(bgtr_pkg::CMD_DRAW, 1, 0, 32'd0, 1);
        wait_quiet();

        // A line height of zero behaves as one row.
        set_cfg(256, 0, 5, 0, 16'hFFFF, 1, 8'h5A, 2);
        push_cmd(bgtr_pkg::CMD_DRAW, 255, 0, 32'd0, 0);
        push_cmd(bgtr_pkg::CMD_DRAW, 0, 0, 32'd0, 1);
        wait_quiet();

        // Random settings, extremes among them. The long output stall falls
        // in the first of them.
        set_cfg(256, 4, $urandom_range(0, 31), $urandom_range(0, 63), 16'hFFFF,
                $urandom_range(1, 4096), $urandom_range(0, 255), 2);
        hold_go = 1'b1;
        random_phase(32);
        wait_quiet();

        set_cfg(256, 1, 31, 63, $urandom_range(60, 300), 4096, 8'hFF, 3);
        random_phase(32);
        wait_quiet();

        set_cfg(256, 32, 0, 0, 16'hFFFF, 1, 8'h00, 2);
        random_phase(32);
        wait_quiet();

        // A zero cell with a zero clip: every glyph sits at a zero or negative x.
        set_cfg($urandom_range(1, 200), 0, $urandom_range(0, 31), 0, 0,
                $urandom_range(1, 8191), $urandom_range(0, 255), 1);
        random_phase(32);
        wait_quiet();

        // Line height above the row cap, widest pitch, top glyph count.
        set_cfg(511, 63, 0, $urandom_range(0, 63), $urandom_range(0, 65535), 8191,
                $urandom_range(0, 255), 0);
        random_phase(32);
        wait_quiet();

        set_cfg($urandom_range(0, 511), $urandom_range(0, 8), $urandom_range(0, 31),
                $urandom_range(0, 63),
                $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(0, 600),
                $urandom_range(1, 8191), $urandom_range(0, 255), $urandom_range(0, 3));
        random_phase(32);
        wait_quiet();

        if (errors == 0 && blit_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/bgtr_pkg.sv
rtl/core/bgtr_ctrl.sv
rtl/core/bgtr_datapath.sv
rtl/core/bitmap_glyph_text_renderer.sv
dv/tb.sv
